[src/lrupr_pkg.sv]
// ----------------------------------------------------------------------------
// lrupr_pkg: shared types and constants for the lru page replacement block
// Sizes of the frame set, page and counter fields, and the records passed
// between the top level and the recency cells.
// ----------------------------------------------------------------------------
package lrupr_pkg;

   // frame set and field sizes
   localparam int MAX_FRAMES = 8;
   localparam int PAGE_BITS  = 8;
   localparam int FRAME_W    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int FILL_W     = $clog2(MAX_FRAMES + 1);
   localparam int CFG_W      = 4;
   localparam int FAULT_W    = 16;
   localparam int PAGE_OUT_W = 8;
   localparam int FIDX_OUT_W = 3;

   // frames_in_use after reset
   localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(6);

   // one recency slot: the frame it names and the page held in that frame
   typedef struct packed {
      logic [FRAME_W-1:0]   frame;
      logic [PAGE_BITS-1:0] page;
   } entry_type;

   // per-cell control from the top level
   typedef struct packed {
      logic pos_valid;   // slot lies below the fill count
      logic shift;       // take the neighbor's entry
      logic load;        // take the new entry
   } cell_ctl_type;

endpackage

[src/lru_page_replacement.sv]
// A result is held in the output register from the cycle after its request transfer.
// Throughput: one access per cycle unless stalled; all cells compare and shift at once.
// A waiting result holds off requests; a request can transfer in the cycle its result leaves.
// Reset (synchronous) clears the fill count and fault count and sets frames_in_use to 6.
// Frame contents need no clearing pass: only slots below the fill count are compared.
// ----------------------------------------------------------------------------
// lru_page_replacement: fully associative LRU page replacement
// A chain of cells kept in recency order (slot 0 least recent) finds hits,
// fills free frames and evicts the least recently used page on a full miss.
// ----------------------------------------------------------------------------
module lru_page_replacement (
   input  logic                             clock,
   input  logic                             reset,
   // configuration
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [lrupr_pkg::CFG_W-1:0]      csr_frames_in_use,
   // requests
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [lrupr_pkg::PAGE_OUT_W-1:0] req_page_number,
   // results
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_hit,
   output logic [lrupr_pkg::FIDX_OUT_W-1:0] rsp_frame_index,
   output logic                             rsp_evicted_valid,
   output logic [lrupr_pkg::PAGE_OUT_W-1:0] rsp_evicted_page,
   output logic [lrupr_pkg::FAULT_W-1:0]    rsp_fault_count
);
   import lrupr_pkg::*;

   logic [CFG_W-1:0]      cfg_ff;
   logic [FILL_W-1:0]     filled_ff;
   logic [FILL_W-1:0]     filled_in;
   logic [FAULT_W-1:0]    fault_ff;
   logic [FAULT_W-1:0]    fault_in;
   logic                  rsp_valid_ff;
   logic                  hit_ff;
   logic [FRAME_W-1:0]    frame_ff;
   logic                  ev_valid_ff;
   logic [PAGE_BITS-1:0]  ev_page_ff;

   logic [PAGE_BITS-1:0]  page_w;
   logic [FILL_W-1:0]     usable_w;
   logic [FILL_W-1:0]     last_pos_w;
   logic                  req_fire;
   logic                  hit_w;
   logic                  full_w;
   logic                  fill_w;
   logic                  evict_w;
   logic [FRAME_W-1:0]    hit_frame_w;
   logic [FRAME_W-1:0]    frame_w;
   entry_type             new_entry_w;
   entry_type             cell_entry [MAX_FRAMES];
   cell_ctl_type          cell_ctl   [MAX_FRAMES];
   logic [MAX_FRAMES-1:0] match_vec;
   logic [MAX_FRAMES:0]   seen_chain;

   // handshakes
   assign csr_ready = 1'b1;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign page_w    = PAGE_BITS'(req_page_number);

   // usable frame limit, clamped to one through the frame count
   always_comb begin
      if (cfg_ff == '0) begin
         usable_w = FILL_W'(1);
      end else if (32'(cfg_ff) > 32'(MAX_FRAMES)) begin
         usable_w = FILL_W'(MAX_FRAMES);
      end else begin
         usable_w = FILL_W'(cfg_ff);
      end
   end

   // recency chain
   assign seen_chain[0] = 1'b0;
   for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
      entry_type nbr_entry;
      if (g == MAX_FRAMES - 1) begin : g_end
         assign nbr_entry = cell_entry[g];
      end else begin : g_mid
         assign nbr_entry = cell_entry[g+1];
      end
      lrupr_cell u_cell (
         .clock      (clock),
         .ctl        (cell_ctl[g]),
         .req_page   (page_w),
         .new_entry  (new_entry_w),
         .next_entry (nbr_entry),
         .seen_in    (seen_chain[g]),
         .entry      (cell_entry[g]),
         .match      (match_vec[g]),
         .seen_out   (seen_chain[g+1])
      );
   end

   // pages are unique across filled frames, so at most one cell matches
   always_comb begin
      hit_frame_w = '0;
      for (int i = 0; i < MAX_FRAMES; i++) begin
         if (match_vec[i]) begin
            hit_frame_w = hit_frame_w | cell_entry[i].frame;
         end
      end
   end

   // access decode
   assign hit_w      = |match_vec;
   assign full_w     = filled_ff >= usable_w;
   assign fill_w     = !hit_w && !full_w;
   assign evict_w    = !hit_w && full_w;
   assign last_pos_w = filled_ff - FILL_W'(1);

   always_comb begin
      if (hit_w) begin
         frame_w = hit_frame_w;
      end else if (full_w) begin
         frame_w = cell_entry[0].frame;
      end else begin
         frame_w = FRAME_W'(filled_ff);
      end
   end

   assign new_entry_w.frame = frame_w;
   assign new_entry_w.page  = page_w;

   // per-cell shift and load
   always_comb begin
      for (int i = 0; i < MAX_FRAMES; i++) begin
         cell_ctl[i].pos_valid = FILL_W'(i) < filled_ff;
         cell_ctl[i].shift     = 1'b0;
         cell_ctl[i].load      = 1'b0;
         if (req_fire) begin
            if (fill_w) begin
               cell_ctl[i].load = FILL_W'(i) == filled_ff;
            end else begin
               // hit shifts from the matching slot up, evict from slot 0 up
               cell_ctl[i].shift = (FILL_W'(i) < last_pos_w) && (evict_w || seen_chain[i+1]);
               cell_ctl[i].load  = FILL_W'(i) == last_pos_w;
            end
         end
      end
   end

   // fill count and saturating fault count
   always_comb begin
      filled_in = filled_ff;
      fault_in  = fault_ff;
      if (req_fire) begin
         if (fill_w) begin
            filled_in = filled_ff + FILL_W'(1);
         end
         if (!hit_w && fault_ff != '1) begin
            fault_in = fault_ff + FAULT_W'(1);
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= CFG_RESET;
         filled_ff    <= '0;
         fault_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            cfg_ff <= csr_frames_in_use;
         end
         filled_ff <= filled_in;
         fault_ff  <= fault_in;
         if (req_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (req_fire) begin
         hit_ff      <= hit_w;
         frame_ff    <= frame_w;
         ev_valid_ff <= evict_w;
         ev_page_ff  <= evict_w ? cell_entry[0].page : '0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = hit_ff;
   assign rsp_frame_index   = FIDX_OUT_W'(frame_ff);
   assign rsp_evicted_valid = ev_valid_ff;
   assign rsp_evicted_page  = PAGE_OUT_W'(ev_page_ff);
   assign rsp_fault_count   = fault_ff;

   // checks
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      filled_ff <= FILL_W'(MAX_FRAMES))
      else $error("fill count beyond frame count");

   a_one_match: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_vec))
      else $error("page resident in more than one frame");

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(hit_ff && ev_valid_ff))
      else $error("eviction reported on a hit");

   a_fault_step: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !hit_w && fault_ff != '1) |=> fault_ff == $past(fault_ff) + FAULT_W'(1))
      else $error("fault count missed a fault");

   a_evict_full: assert property (@(posedge clock) disable iff (reset)
      (req_fire && evict_w) |=> filled_ff == $past(filled_ff))
      else $error("eviction changed the fill count");

endmodule

[src/lrupr_cell.sv]
// ----------------------------------------------------------------------------
// lrupr_cell: one slot of the recency chain
// Holds a frame id and its page, compares against the requested page, passes
// the "match seen" flag up the chain and shifts in its neighbor on demand.
// ----------------------------------------------------------------------------
module lrupr_cell (
   input  logic                           clock,
   input  lrupr_pkg::cell_ctl_type        ctl,
   input  logic [lrupr_pkg::PAGE_BITS-1:0] req_page,
   input  lrupr_pkg::entry_type           new_entry,
   input  lrupr_pkg::entry_type           next_entry,
   input  logic                           seen_in,
   output lrupr_pkg::entry_type           entry,
   output logic                           match,
   output logic                           seen_out
);
   import lrupr_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // compare and chain the match flag toward the most recent end
   assign match    = ctl.pos_valid && (entry_ff.page == req_page);
   assign seen_out = seen_in | match;
   assign entry    = entry_ff;

   // load beats shift, otherwise hold
   always_comb begin
      entry_in = entry_ff;
      if (ctl.load) begin
         entry_in = new_entry;
      end else if (ctl.shift) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

[tb/lru_page_replacement_check.sv]
// ----------------------------------------------------------------------------
// lru_page_replacement_check: result checker for the lru page replacement block
// Watches the configuration, request and result channels, keeps its own copy
// of the frame set and recency chain, predicts each access outcome and
// compares every result transfer against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module lru_page_replacement_check (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [lrupr_pkg::CFG_W-1:0]      csr_frames_in_use,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic [lrupr_pkg::PAGE_OUT_W-1:0] req_page_number,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic                             rsp_hit,
   input  logic [lrupr_pkg::FIDX_OUT_W-1:0] rsp_frame_index,
   input  logic                             rsp_evicted_valid,
   input  logic [lrupr_pkg::PAGE_OUT_W-1:0] rsp_evicted_page,
   input  logic [lrupr_pkg::FAULT_W-1:0]    rsp_fault_count,
   output int                               mismatch_count,
   output int                               outstanding_results
);

   // outcome of one page access
   typedef struct packed {
      logic                             hit;
      logic [lrupr_pkg::FIDX_OUT_W-1:0] frame_index;
      logic                             evicted_valid;
      logic [lrupr_pkg::PAGE_OUT_W-1:0] evicted_page;
      logic [lrupr_pkg::FAULT_W-1:0]    fault_count;
   } access_outcome_type;

   // shadow of the frame set
   logic [lrupr_pkg::PAGE_BITS-1:0] frame_page [lrupr_pkg::MAX_FRAMES];
   logic [lrupr_pkg::FRAME_W-1:0]   lru_chain  [lrupr_pkg::MAX_FRAMES];
   logic [lrupr_pkg::FILL_W-1:0]    filled;
   logic [lrupr_pkg::FAULT_W-1:0]   faults_seen;
   logic [lrupr_pkg::CFG_W-1:0]     frame_limit;

   access_outcome_type predicted_accesses [$];
   int                 errors = 0;

   // drop chain position pos and append frame as most recent
   function automatic void move_to_newest(int pos, logic [lrupr_pkg::FRAME_W-1:0] frame);
      for (int i = pos; i + 1 < int'(filled); i++)
         lru_chain[i] = lru_chain[i + 1];
      if (filled > 0)
         lru_chain[lrupr_pkg::FRAME_W'(int'(filled) - 1)] = frame;
   endfunction

   // one access: search, then promote, fill or evict
   function automatic access_outcome_type apply_access(logic [lrupr_pkg::PAGE_BITS-1:0] page);
      access_outcome_type            res;
      logic [lrupr_pkg::FRAME_W-1:0] frame;
      int                            limit;
      int                            pos;
      res   = '0;
      frame = '0;
      if (frame_limit == 0)
         limit = 1;
      else if (frame_limit > lrupr_pkg::MAX_FRAMES)
         limit = lrupr_pkg::MAX_FRAMES;
      else
         limit = int'(frame_limit);

      for (int f = 0; f < int'(filled); f++) begin
         if (!res.hit && frame_page[f] == page) begin
            res.hit = 1'b1;
            frame   = lrupr_pkg::FRAME_W'(f);
         end
      end

      if (res.hit) begin
         pos = 0;
         while (pos < int'(filled) && lru_chain[pos] != frame)
            pos++;
         if (pos < int'(filled))
            move_to_newest(pos, frame);
      end else begin
         if (int'(filled) < limit) begin
            // free frame left
            frame             = lrupr_pkg::FRAME_W'(filled);
            frame_page[frame] = page;
            lru_chain[frame]  = frame;
            filled            = filled + lrupr_pkg::FILL_W'(1);
         end else begin
            // full, also when the limit was lowered below the fill count
            frame             = lru_chain[0];
            res.evicted_valid = 1'b1;
            res.evicted_page  = frame_page[frame];
            frame_page[frame] = page;
            move_to_newest(0, frame);
         end
         if (faults_seen != '1)
            faults_seen = faults_seen + lrupr_pkg::FAULT_W'(1);
      end

      res.frame_index = frame;
      res.fault_count = faults_seen;
      return res;
   endfunction

   task automatic report_field(string field, int unsigned want, int unsigned got);
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      errors++;
   endtask

   // follow every transfer on the three channels
   always @(posedge clock) begin : watch
      access_outcome_type want;
      if (reset) begin
         filled      = '0;
         faults_seen = '0;
         frame_limit = lrupr_pkg::CFG_RESET;
         predicted_accesses.delete();
      end else begin
         if (csr_valid && csr_ready)
            frame_limit = csr_frames_in_use;

         // result transfer against the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (predicted_accesses.size() == 0) begin
               $display("%0t: result transfer with nothing expected, actual hit %0b frame %0d",
                        $time, rsp_hit, rsp_frame_index);
               errors++;
            end else begin
               want = predicted_accesses[0];
               predicted_accesses.delete(0);
               if (rsp_hit !== want.hit)
                  report_field("hit", want.hit, rsp_hit);
               if (rsp_frame_index !== want.frame_index)
                  report_field("frame_index", want.frame_index, rsp_frame_index);
               if (rsp_evicted_valid !== want.evicted_valid)
                  report_field("evicted_valid", want.evicted_valid, rsp_evicted_valid);
               if (rsp_evicted_page !== want.evicted_page)
                  report_field("evicted_page", want.evicted_page, rsp_evicted_page);
               if (rsp_fault_count !== want.fault_count)
                  report_field("fault_count", want.fault_count, rsp_fault_count);
            end
         end

         if (req_valid && req_ready)
            predicted_accesses = {predicted_accesses, apply_access(req_page_number)};
      end
      mismatch_count      <= errors;
      outstanding_results <= predicted_accesses.size();
   end

endmodule

[tb/lru_page_replacement_test.sv]
// ----------------------------------------------------------------------------
// lru_page_replacement_test: top level of the lru page replacement testbench
// Drives directed and random page accesses under several frame limits, with
// random gaps on the request side and random stalls on the result side, and
// reports the checker's verdict.
// ----------------------------------------------------------------------------
module lru_page_replacement_test;

   logic                             clock             = 1'b0;
   logic                             reset             = 1'b1;
   logic                             csr_valid         = 1'b0;
   logic                             csr_ready;
   logic [lrupr_pkg::CFG_W-1:0]      csr_frames_in_use = '0;
   logic                             req_valid         = 1'b0;
   logic                             req_ready;
   logic [lrupr_pkg::PAGE_OUT_W-1:0] req_page_number   = '0;
   logic                             rsp_valid;
   logic                             rsp_ready         = 1'b0;
   logic                             rsp_hit;
   logic [lrupr_pkg::FIDX_OUT_W-1:0] rsp_frame_index;
   logic                             rsp_evicted_valid;
   logic [lrupr_pkg::PAGE_OUT_W-1:0] rsp_evicted_page;
   logic [lrupr_pkg::FAULT_W-1:0]    rsp_fault_count;

   int mismatch_count;
   int outstanding_results;
   bit idle_on    = 1'b0;
   int ready_hold = 0;

   always #5 clock = ~clock;

   lru_page_replacement i_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_frames_in_use (csr_frames_in_use),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_page_number   (req_page_number),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_hit           (rsp_hit),
      .rsp_frame_index   (rsp_frame_index),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_page  (rsp_evicted_page),
      .rsp_fault_count   (rsp_fault_count)
   );

   lru_page_replacement_check i_check (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_frames_in_use   (csr_frames_in_use),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_page_number     (req_page_number),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_hit             (rsp_hit),
      .rsp_frame_index     (rsp_frame_index),
      .rsp_evicted_valid   (rsp_evicted_valid),
      .rsp_evicted_page    (rsp_evicted_page),
      .rsp_fault_count     (rsp_fault_count),
      .mismatch_count      (mismatch_count),
      .outstanding_results (outstanding_results)
   );

   // mostly short idle stretches, a few long ones
   function automatic int idle_length();
      int r;
      if (!idle_on)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   // result side stalls
   always @(posedge clock) begin : ready_gen
      int stall;
      if (ready_hold > 0) begin
         rsp_ready  <= 1'b0;
         ready_hold <= ready_hold - 1;
      end else begin
         stall = idle_length();
         rsp_ready  <= (stall == 0);
         ready_hold <= (stall > 0) ? stall - 1 : 0;
      end
   end

   // one request transfer, after an optional gap
   task automatic send_page(input logic [lrupr_pkg::PAGE_OUT_W-1:0] page);
      int gap;
      gap = idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_page_number <= page;
      do @(posedge clock); while (!req_ready);
   endtask

   // stop requests and wait for every outstanding result
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding_results != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_frame_limit(input logic [lrupr_pkg::CFG_W-1:0] value);
      drain();
      csr_valid         <= 1'b1;
      csr_frames_in_use <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // page from a small working set for hits, or anywhere
   function automatic logic [lrupr_pkg::PAGE_OUT_W-1:0] pick_page(
      input logic [lrupr_pkg::PAGE_OUT_W-1:0] pool_base);
      if ($urandom_range(0, 99) < 70)
         return pool_base + lrupr_pkg::PAGE_OUT_W'($urandom_range(0, 11));
      return lrupr_pkg::PAGE_OUT_W'($urandom_range(0, 255));
   endfunction

   // stimulus
   initial begin : stimulus
      logic [lrupr_pkg::CFG_W-1:0]      phase_limits [6];
      logic [lrupr_pkg::PAGE_OUT_W-1:0] pool_base;
      phase_limits = '{4'd8, 4'd1, 4'd3, 4'd15, 4'd0, 4'd6};

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // limit zero right after reset behaves as one frame
      write_frame_limit(4'd0);
      send_page(8'h00);
      send_page(8'hFF);
      send_page(8'hFF);

      // limit too large behaves as all frames; fill all, hit, evict
      write_frame_limit(4'd15);
      send_page(8'h00);
      send_page(8'h55);
      send_page(8'hAA);
      send_page(8'h01);
      send_page(8'h80);
      send_page(8'h7F);
      send_page(8'hFE);
      send_page(8'h80);
      send_page(8'h11);

      // limit lowered below the fill count: all filled frames still hit
      write_frame_limit(4'd2);
      send_page(8'h33);
      send_page(8'h33);
      send_page(8'hFE);
      send_page(8'h55);

      // random phases under several limits
      foreach (phase_limits[k]) begin
         write_frame_limit(phase_limits[k]);
         pool_base = lrupr_pkg::PAGE_OUT_W'($urandom_range(0, 255));
         for (int n = 0; n < 70; n++) begin
            if (n % 25 == 0)
               idle_on = ($urandom_range(0, 3) != 0);
            send_page(pick_page(pool_base));
         end
      end

      // closing random phase with stalls on both sides
      idle_on = 1'b1;
      write_frame_limit(4'd4);
      pool_base = lrupr_pkg::PAGE_OUT_W'($urandom_range(0, 255));
      for (int n = 0; n < 30; n++)
         send_page(pick_page(pool_base));

      drain();
      if (mismatch_count == 0)
         $display("[lru_page_replacement] OK");
      else
         $display("[lru_page_replacement] ERROR");
      $finish;
   end

   // run limit
   initial begin
      #5000000;
      $display("[lru_page_replacement] ERROR");
      $finish;
   end

endmodule
